// ----- sv/psf_pkg.sv -----
// Package for the power spectrogram frame unit: shared widths, table types
// and the constant functions that build the cosine and Hann window tables.
// No dependencies.
`default_nettype none

package psf_pkg;

  localparam int MAX_N = 64;
  localparam int MUL_W = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef logic signed [16:0] q15_tab_t [MAX_N];

  typedef enum logic [2:0] {
    REG_HOP    = 3'd0,
    REG_MULT   = 3'd1,
    REG_SHIFT  = 3'd2,
    REG_LOG    = 3'd3,
    REG_OFFSET = 3'd4
  } reg_idx_e;

  // Taylor divisors (2i-1)*(2i)
  function automatic longint taylor_div(input int i);
    longint d;
    case (i)
      1: d = 2;
      2: d = 12;
      3: d = 30;
      4: d = 56;
      5: d = 90;
      6: d = 132;
      default: d = 182;
    endcase
    return d;
  endfunction

  // restoring division truncated toward zero, den positive, elaboration only
  function automatic longint div_trunc(input longint num, input longint den);
    logic [63:0] mag;
    logic [64:0] rem;
    logic [63:0] q;
    mag = (num < 0) ? 64'(-num) : 64'(num);
    rem = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], mag[b]};
      if (rem >= {1'b0, 64'(den)}) begin
        rem = rem - {1'b0, 64'(den)};
        q[b] = 1'b1;
      end
    end
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // cos on a quarter turn, p in 0..16384, Q15 result 0..32768
  function automatic logic signed [16:0] cos_quarter(input logic [14:0] p);
    logic [63:0] r;
    longint r2;
    longint t;
    longint sum;
    longint pr;
    r = (64'(p) * TWO_PI_Q30) >> 16;
    r2 = longint'((r * r) >> 30);
    t = longint'(1) <<< 30;
    sum = t;
    for (int i = 1; i <= 7; i++) begin
      pr = t * r2;
      pr = (pr < 0) ? -((-pr) >>> 30) : (pr >>> 30);
      t = -div_trunc(pr, taylor_div(i));
      sum = sum + t;
    end
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) <<< 30)) sum = longint'(1) <<< 30;
    return 17'((sum + 16384) >>> 15);
  endfunction

  function automatic logic signed [16:0] cos_turns(input logic [15:0] a);
    logic [14:0] p;
    logic [14:0] q;
    logic signed [16:0] c;
    p = {1'b0, a[13:0]};
    q = 15'(16384) - p;
    case (a[15:14])
      2'd0: c = cos_quarter(p);
      2'd1: c = -cos_quarter(q);
      2'd2: c = -cos_quarter(p);
      default: c = cos_quarter(q);
    endcase
    return c;
  endfunction

  // restoring division, elaboration only
  function automatic logic [31:0] udiv(input logic [31:0] num, input logic [31:0] den);
    logic [32:0] rem;
    logic [31:0] q;
    rem = '0;
    q = '0;
    for (int b = 31; b >= 0; b--) begin
      rem = {rem[31:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic q15_tab_t build_cos(input int log2n);
    q15_tab_t tab;
    for (int m = 0; m < MAX_N; m++) begin
      if (m < (1 << log2n)) tab[m] = cos_turns(16'(m << (16 - log2n)));
      else tab[m] = '0;
    end
    return tab;
  endfunction

  function automatic q15_tab_t build_win(input int n);
    q15_tab_t tab;
    logic [31:0] f;
    int w;
    for (int i = 0; i < MAX_N; i++) begin
      if (i < n) begin
        f = udiv(32'(i * 65536 + ((n - 1) >> 1)), 32'(n - 1));
        w = (32768 - int'(cos_turns(f[15:0])) + 1) >> 1;
        tab[i] = 17'(w);
      end else begin
        tab[i] = '0;
      end
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

// ----- sv/psf_in_if.sv -----
// Input channel of the power spectrogram frame unit: one audio sample a word.
// No dependencies.
`default_nettype none

interface psf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic               first_of_signal;

  modport source (output valid, sample, first_of_signal, input ready);
  modport sink (input valid, sample, first_of_signal, output ready);
endinterface

`default_nettype wire

// ----- sv/psf_out_if.sv -----
// Output channel of the power spectrogram frame unit: one power bin a word.
// No dependencies.
`default_nettype none

interface psf_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         bin_index;
  logic signed [31:0] bin_value;
  logic               last_bin;

  modport source (output valid, bin_index, bin_value, last_bin, input ready);
  modport sink (input valid, bin_index, bin_value, last_bin, output ready);
endinterface

`default_nettype wire

// ----- sv/psf_mul.sv -----
// Shared signed multiplier with registered product for the frame unit.
// Depends on psf_pkg.
`default_nettype none

module psf_mul (
  input  wire logic                               clk_i,
  input  wire logic signed [psf_pkg::MUL_W-1:0]   a_i,
  input  wire logic signed [psf_pkg::MUL_W-1:0]   b_i,
  output      logic signed [psf_pkg::PROD_W-1:0]  prod_o
);

  logic signed [psf_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= psf_pkg::PROD_W'(a_i) * psf_pkg::PROD_W'(b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- sv/power_spectrogram_frames_unit.sv -----
// Top level of the power spectrogram frame unit: framing, window, DFT, scale, log.
// Depends on psf_pkg, psf_in_if, psf_out_if and psf_mul.
//
// Samples arrive one word at a time on s_in; bins leave on m_out, DC first,
// last_bin set on the Nyquist bin. A sample that ends no frame is taken
// without leaving idle. Once FFT_SIZE samples of a signal are in, and then every
// hop_length samples, the block computes a frame and holds s_in.ready low
// until the last bin is loaded into the output register.
// All arithmetic goes through one 33x33 multiplier under a state sequencer:
// each frame is windowed, then each bin runs the direct DFT, power and scale,
// followed in log mode by a normalize loop and 24 squarings.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must do so only while idle, which the block itself does not enforce.
// The output register lets the next bin be computed while a bin waits; a
// stalled receiver holds the sequencer only when the next bin is ready.
// Reset (rst_ni low, asynchronous) clears framing counters and output valid
// and loads the register defaults; buffer contents are never read unwritten.
`default_nettype none

module power_spectrogram_frames_unit #(
  parameter int FFT_SIZE    = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  psf_in_if.sink           s_in,
  psf_out_if.source        m_out
);

  localparam int ADDR_W = $clog2(FFT_SIZE);
  localparam int FILL_W = ADDR_W + 1;
  localparam logic [ADDR_W-1:0] LAST_N = ADDR_W'(FFT_SIZE - 1);
  localparam logic [ADDR_W-1:0] HALF = ADDR_W'(FFT_SIZE / 2);
  localparam logic [ADDR_W-1:0] QTR = ADDR_W'(FFT_SIZE / 4);
  localparam int SHIFT_S = 16 - SAMPLE_BITS;
  localparam psf_pkg::q15_tab_t COS_TAB = psf_pkg::build_cos(ADDR_W);
  localparam psf_pkg::q15_tab_t WIN_TAB = psf_pkg::build_win(FFT_SIZE);

  typedef enum logic [4:0] {
    ST_IDLE, ST_WIN_RD, ST_WIN_MUL, ST_WIN_WR,
    ST_DFT_RD, ST_DFT_RE, ST_DFT_IM, ST_DFT_ACC,
    ST_PW_RND, ST_PW_SQR, ST_PW_SQI, ST_PW_SUM,
    ST_SC_LO, ST_SC_HI, ST_SC_ADD, ST_SC_SHF,
    ST_LG_PREP, ST_LG_NORM, ST_LG_SQ, ST_LG_UPD, ST_LG_LN, ST_LG_RND,
    ST_OUT
  } state_e;

  state_e state_q;

  // configuration
  logic [6:0]  hop_q;
  logic [31:0] mult_q;
  logic [5:0]  shift_q;
  logic        log_q;
  logic [15:0] off_q;

  // framing
  logic [FILL_W-1:0] fc_q;
  logic [6:0]        hc_q;
  logic [ADDR_W-1:0] wp_q;

  // memories
  logic [15:0]        buf_mem [FFT_SIZE];
  logic [15:0]        buf_rd_q;
  logic signed [17:0] work_mem [FFT_SIZE];
  logic signed [17:0] work_rd_q;

  // datapath
  logic [ADDR_W-1:0]  n_q, k_q, ph_q;
  logic signed [39:0] re_q, im_q;
  logic signed [24:0] rr_q, ri_q;
  logic [45:0]        pw_q;
  logic [63:0]        lo_q;
  logic [77:0]        full_q;
  logic [31:0]        res_q;
  logic [33:0]        m_q;
  logic [5:0]         e_q;
  logic [23:0]        frac_q;
  logic [4:0]         it_q;

  // output register
  logic               ov_q;
  logic [5:0]         oidx_q;
  logic [31:0]        oval_q;
  logic               olast_q;

  logic signed [psf_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [psf_pkg::PROD_W-1:0] prod;

  psf_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // input side
  logic              acc;
  logic              first;
  logic [ADDR_W-1:0] wp_eff;
  logic [FILL_W-1:0] fc_eff;
  logic [6:0]        hc_eff;
  logic [7:0]        hc_inc;
  logic [6:0]        hop_eff;
  logic              frame_go;

  assign s_in.ready = (state_q == ST_IDLE);
  assign acc = s_in.valid && s_in.ready;
  assign first = s_in.first_of_signal;
  assign wp_eff = first ? '0 : wp_q;
  assign fc_eff = first ? '0 : fc_q;
  assign hc_eff = first ? '0 : hc_q;
  assign hc_inc = {1'b0, hc_eff} + 8'd1;
  assign hop_eff = (hop_q == '0) ? 7'd1 : hop_q;
  assign frame_go = (fc_eff < FILL_W'(FFT_SIZE))
                  ? ((fc_eff + FILL_W'(1)) == FILL_W'(FFT_SIZE))
                  : (hc_inc >= {1'b0, hop_eff});

  // memory addressing
  logic [ADDR_W-1:0] buf_ra;
  logic [ADDR_W-1:0] work_ra;
  logic              work_we;
  logic signed [psf_pkg::PROD_W-1:0] x_rnd;
  logic signed [15:0] samp_ext;

  assign buf_ra = wp_q + n_q;
  assign work_ra = n_q + ADDR_W'((state_q == ST_DFT_IM) || (state_q == ST_DFT_ACC));
  assign work_we = (state_q == ST_WIN_WR);
  assign x_rnd = (prod + psf_pkg::PROD_W'(16384)) >>> 15;
  assign samp_ext = $signed(buf_rd_q << SHIFT_S) >>> SHIFT_S;

  always_ff @(posedge clk_i) begin
    if (acc) buf_mem[wp_eff] <= s_in.sample;
    buf_rd_q <= buf_mem[buf_ra];
  end

  always_ff @(posedge clk_i) begin
    if (work_we) work_mem[n_q] <= 18'(x_rnd);
    work_rd_q <= work_mem[work_ra];
  end

  // shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_WIN_MUL: begin
        mul_a = 33'(samp_ext);
        mul_b = 33'(WIN_TAB[n_q]);
      end
      ST_DFT_RE: begin
        mul_a = 33'(work_rd_q);
        mul_b = 33'(COS_TAB[ph_q]);
      end
      ST_DFT_IM: begin
        mul_a = 33'(work_rd_q);
        mul_b = 33'(COS_TAB[ADDR_W'(ph_q - QTR)]);
      end
      ST_PW_SQR: begin
        mul_a = 33'(rr_q);
        mul_b = 33'(rr_q);
      end
      ST_PW_SQI: begin
        mul_a = 33'(ri_q);
        mul_b = 33'(ri_q);
      end
      ST_SC_LO: begin
        mul_a = {1'b0, pw_q[31:0]};
        mul_b = {1'b0, mult_q};
      end
      ST_SC_HI: begin
        mul_a = {19'd0, pw_q[45:32]};
        mul_b = {1'b0, mult_q};
      end
      ST_LG_SQ: begin
        mul_a = {1'b0, m_q[31:0]};
        mul_b = {1'b0, m_q[31:0]};
      end
      ST_LG_LN: begin
        mul_a = {3'd0, e_q, frac_q};
        mul_b = {1'b0, psf_pkg::LN2_Q32};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // combinational helpers for the sequencer
  logic signed [39:0] re_rnd, im_rnd;
  logic [46:0]        pw_sum;
  logic [77:0]        shd;
  logic [32:0]        lg_v;
  logic [31:0]        sq;
  logic               interior;
  logic               out_take;

  assign re_rnd = (re_q + 40'sd16384) >>> 15;
  assign im_rnd = (im_q + 40'sd16384) >>> 15;
  assign pw_sum = {1'b0, pw_q} + {1'b0, prod[45:0]};
  assign shd = full_q >> shift_q;
  assign lg_v = {1'b0, res_q} + 33'(off_q);
  assign sq = prod[61:30];
  assign interior = (k_q != '0) && (k_q != HALF);
  assign out_take = !ov_q || m_out.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      hop_q   <= 7'd32;
      mult_q  <= 32'd65536;
      shift_q <= 6'd16;
      log_q   <= 1'b0;
      off_q   <= 16'd1;
      fc_q    <= '0;
      hc_q    <= '0;
      wp_q    <= '0;
      ov_q    <= 1'b0;
      n_q     <= '0;
      k_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          psf_pkg::REG_HOP:    hop_q   <= cfg_data_i[6:0];
          psf_pkg::REG_MULT:   mult_q  <= cfg_data_i;
          psf_pkg::REG_SHIFT:  shift_q <= cfg_data_i[5:0];
          psf_pkg::REG_LOG:    log_q   <= cfg_data_i[0];
          psf_pkg::REG_OFFSET: off_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      // drop valid on a taken word; ST_OUT reloads it itself
      if (m_out.valid && m_out.ready && (state_q != ST_OUT)) ov_q <= 1'b0;

      case (state_q)
        ST_IDLE: begin
          if (acc) begin
            wp_q <= wp_eff + ADDR_W'(1);
            if (fc_eff < FILL_W'(FFT_SIZE)) begin
              fc_q <= fc_eff + FILL_W'(1);
              hc_q <= frame_go ? '0 : hc_eff;
            end else begin
              fc_q <= fc_eff;
              hc_q <= frame_go ? '0 : hc_inc[6:0];
            end
            if (frame_go) begin
              n_q <= '0;
              state_q <= ST_WIN_RD;
            end
          end
        end
        ST_WIN_RD:  state_q <= ST_WIN_MUL;
        ST_WIN_MUL: state_q <= ST_WIN_WR;
        ST_WIN_WR: begin
          n_q <= n_q + ADDR_W'(1);
          if (n_q == LAST_N) begin
            k_q <= '0;
            state_q <= ST_DFT_RD;
          end else begin
            state_q <= ST_WIN_RD;
          end
        end
        ST_DFT_RD: begin
          re_q <= '0;
          im_q <= '0;
          ph_q <= '0;
          n_q <= '0;
          state_q <= ST_DFT_RE;
        end
        ST_DFT_RE: state_q <= ST_DFT_IM;
        ST_DFT_IM: begin
          re_q <= re_q + $signed(prod[39:0]);
          state_q <= ST_DFT_ACC;
        end
        ST_DFT_ACC: begin
          im_q <= im_q - $signed(prod[39:0]);
          n_q <= n_q + ADDR_W'(1);
          ph_q <= ph_q + k_q;
          state_q <= (n_q == LAST_N) ? ST_PW_RND : ST_DFT_RE;
        end
        ST_PW_RND: begin
          rr_q <= 25'(re_rnd);
          ri_q <= 25'(im_rnd);
          state_q <= ST_PW_SQR;
        end
        ST_PW_SQR: state_q <= ST_PW_SQI;
        ST_PW_SQI: begin
          pw_q <= prod[45:0];
          state_q <= ST_PW_SUM;
        end
        ST_PW_SUM: begin
          pw_q <= interior ? {pw_sum[44:0], 1'b0} : pw_sum[45:0];
          state_q <= ST_SC_LO;
        end
        ST_SC_LO: state_q <= ST_SC_HI;
        ST_SC_HI: begin
          lo_q <= prod[63:0];
          state_q <= ST_SC_ADD;
        end
        ST_SC_ADD: begin
          full_q <= 78'(lo_q) + (78'(prod[45:0]) << 32);
          state_q <= ST_SC_SHF;
        end
        ST_SC_SHF: begin
          res_q <= (|shd[77:31]) ? 32'h7FFF_FFFF : {1'b0, shd[30:0]};
          state_q <= log_q ? ST_LG_PREP : ST_OUT;
        end
        ST_LG_PREP: begin
          m_q <= 34'(lg_v);
          e_q <= 6'd30;
          frac_q <= '0;
          it_q <= '0;
          if (lg_v == '0) begin
            res_q <= 32'h8000_0000;
            state_q <= ST_OUT;
          end else begin
            state_q <= ST_LG_NORM;
          end
        end
        ST_LG_NORM: begin
          // bring the leading one to bit 30
          if (m_q[33:31] != '0) begin
            m_q <= m_q >> 1;
            e_q <= e_q + 6'd1;
          end else if (!m_q[30]) begin
            m_q <= m_q << 1;
            e_q <= e_q - 6'd1;
          end else begin
            state_q <= ST_LG_SQ;
          end
        end
        ST_LG_SQ: state_q <= ST_LG_UPD;
        ST_LG_UPD: begin
          frac_q <= {frac_q[22:0], sq[31]};
          m_q <= sq[31] ? {3'd0, sq[31:1]} : {2'd0, sq};
          it_q <= it_q + 5'd1;
          state_q <= (it_q == 5'd23) ? ST_LG_LN : ST_LG_SQ;
        end
        ST_LG_LN: state_q <= ST_LG_RND;
        ST_LG_RND: begin
          res_q <= 32'((prod + (psf_pkg::PROD_W'(1) <<< 39)) >>> 40);
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          // load the bin once the output register is free
          if (out_take) begin
            ov_q <= 1'b1;
            oidx_q <= 6'(k_q);
            oval_q <= res_q;
            olast_q <= (k_q == HALF);
            if (k_q == HALF) begin
              state_q <= ST_IDLE;
            end else begin
              k_q <= k_q + ADDR_W'(1);
              state_q <= ST_DFT_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_out.valid = ov_q;
  assign m_out.bin_index = oidx_q;
  assign m_out.bin_value = $signed(oval_q);
  assign m_out.last_bin = olast_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= FILL_W'(FFT_SIZE))
    else $error("fill count beyond frame size");

  a_last_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (olast_q == (oidx_q == 6'(FFT_SIZE / 2))))
    else $error("last_bin does not match Nyquist index");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && frame_go) |=> (state_q == ST_WIN_RD && !s_in.ready))
    else $error("frame did not start after triggering sample");

  a_log_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LG_SQ) |-> (m_q[33:30] == 4'b0001))
    else $error("log mantissa not normalized");

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for power_spectrogram_frames_unit: drives audio words,
// predicts every power bin in place and checks each bin leaving the block.
// Depends on psf_pkg, psf_in_if, psf_out_if and the unit itself.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N     = 64;
  localparam int NBINS = N / 2 + 1;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct {
    logic signed [15:0] sample;
    logic               first;
  } sample_word_t;

  typedef struct {
    logic [5:0]         idx;
    logic signed [31:0] val;
    logic               last;
  } bin_word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;

  psf_in_if  in_ch ();
  psf_out_if out_ch ();

  power_spectrogram_frames_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_in       (in_ch),
    .m_out      (out_ch)
  );

  // predictor state and register shadow
  logic [15:0]  frame_buf [N];
  longint       windowed [N];
  int unsigned  fill_cnt, hop_cnt, wr_ptr;
  logic [6:0]   hop_len;
  logic [31:0]  scale_mult;
  logic [5:0]   scale_shift;
  logic         log_on;
  logic [15:0]  log_eps;
  int           hann [N];
  int           cos_tab [N];
  int           sin_tab [N];

  sample_word_t pending_samples [$];
  bin_word_t    expected_bins [$];
  int           mismatches;
  int           samples_sent;
  int           frames_seen;
  int           bins_checked;
  int           idle_cycles;
  bit           reset_done;
  bit           drv_busy;
  bit           in_taken;
  bit           out_taken;
  int           in_gap;
  int           out_stall;
  bit           in_burst;
  bit           out_burst;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int cos_quarter_turn(int unsigned p);
    logic [63:0] r;
    longint      r2;
    longint      t;
    longint      acc;
    r   = (64'(p) * psf_pkg::TWO_PI_Q30) >> 16;
    r2  = longint'((r * r) >> 30);
    t   = longint'(1) <<< 30;
    acc = t;
    for (int i = 1; i <= 7; i++) begin
      t = -((t * r2) / (longint'(1) <<< 30)) / longint'((2 * i - 1) * (2 * i));
      acc += t;
    end
    if (acc < 0) acc = 0;
    if (acc > (longint'(1) <<< 30)) acc = longint'(1) <<< 30;
    return int'((acc + 16384) >>> 15);
  endfunction

  function automatic int cos_of_turn(int unsigned a);
    int unsigned p;
    p = a & 32'h3FFF;
    case ((a >> 14) & 3)
      0: return cos_quarter_turn(p);
      1: return -cos_quarter_turn(16384 - p);
      2: return -cos_quarter_turn(p);
      default: return cos_quarter_turn(16384 - p);
    endcase
  endfunction

  function automatic longint round_q15(longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic logic [31:0] scale_bin(logic [63:0] power);
    logic [127:0] prod;
    prod = (128'(power) * 128'(scale_mult)) >> scale_shift;
    if (prod > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return prod[31:0];
  endfunction

  function automatic logic [31:0] ln_q16(logic [63:0] v);
    int unsigned e;
    logic [63:0] m;
    logic [63:0] frac;
    logic [63:0] l;
    if (v == 0) return 32'h8000_0000;
    e = 0;
    frac = 0;
    while (e < 63 && (v >> (e + 1)) != 0) e++;
    m = (e <= 30) ? (v << (30 - e)) : (v >> (e - 30));
    for (int i = 0; i < 24; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    l = (64'(e) << 24) | frac;
    return 32'((l * 64'(psf_pkg::LN2_Q32) + (64'd1 << 39)) >> 40);
  endfunction

  task automatic compute_frame_bins();
    longint      re, im, rr, ri;
    logic [63:0] power;
    logic [31:0] val;
    bin_word_t   b;
    for (int n = 0; n < N; n++)
      windowed[n] = round_q15(longint'($signed(frame_buf[(wr_ptr + n) % N])) * hann[n]);
    for (int k = 0; k < NBINS; k++) begin
      re = 0;
      im = 0;
      for (int n = 0; n < N; n++) begin
        re += windowed[n] * cos_tab[(k * n) % N];
        im -= windowed[n] * sin_tab[(k * n) % N];
      end
      rr = round_q15(re);
      ri = round_q15(im);
      power = 64'(rr * rr) + 64'(ri * ri);
      if (k != 0 && k != N / 2) power = power * 2;
      val = scale_bin(power);
      if (log_on) val = ln_q16(64'(val) + 64'(log_eps));
      b.idx  = 6'(k);
      b.val  = val;
      b.last = (k == N / 2);
      expected_bins = {expected_bins, b};
    end
    frames_seen++;
  endtask

  task automatic predict_sample(sample_word_t w);
    int unsigned hop;
    hop = (hop_len == 0) ? 1 : hop_len;
    if (w.first) begin
      fill_cnt = 0;
      hop_cnt  = 0;
      wr_ptr   = 0;
    end
    frame_buf[wr_ptr] = w.sample;
    wr_ptr = (wr_ptr + 1) % N;
    if (fill_cnt < N) begin
      fill_cnt++;
      if (fill_cnt == N) begin
        hop_cnt = 0;
        compute_frame_bins();
      end
    end else begin
      hop_cnt++;
      if (hop_cnt >= hop) begin
        hop_cnt = 0;
        compute_frame_bins();
      end
    end
  endtask

  task automatic write_reg(psf_pkg::reg_idx_e idx, logic [31:0] v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      psf_pkg::REG_HOP:    hop_len     = v[6:0];
      psf_pkg::REG_MULT:   scale_mult  = v;
      psf_pkg::REG_SHIFT:  scale_shift = v[5:0];
      psf_pkg::REG_LOG:    log_on      = v[0];
      psf_pkg::REG_OFFSET: log_eps     = v[15:0];
      default: ;
    endcase
  endtask

  // hold until the driver is drained and every bin is back, then let the block settle
  task automatic wait_quiet();
    wait (pending_samples.size() == 0 && !drv_busy && expected_bins.size() == 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] draw_sample(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 63)) - 16'sd32;
      2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      default: return 16'sh0000;
    endcase
  endfunction

  task automatic queue_word(logic signed [15:0] s, logic first);
    sample_word_t w;
    w.sample = s;
    w.first  = first;
    pending_samples = {pending_samples, w};
    samples_sent++;
  endtask

  // one signal: restart word, enough words to fill, then nframes - 1 hops plus less than one hop of spare words
  task automatic push_signal(int nframes, int mode);
    int unsigned hop;
    int total;
    hop = (hop_len == 0) ? 1 : hop_len;
    total = N + (nframes - 1) * hop + $urandom_range(0, hop - 1);
    for (int i = 0; i < total; i++)
      queue_word(draw_sample(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : mode),
                 i == 0);
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (reset_done) begin
      if (in_taken) begin
        in_taken = 1'b0;
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          sample_word_t w;
          w = pending_samples.pop_front();
          in_ch.sample          <= w.sample;
          in_ch.first_of_signal <= w.first;
          in_ch.valid           <= 1'b1;
          drv_busy = 1'b1;
          if ($urandom_range(0, 19) == 0) in_burst = ~in_burst;
          in_gap = in_burst ? 0 : $urandom_range(0, 9);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // output ready driver
  always @(negedge clk_i) begin
    if (reset_done) begin
      if (out_taken) begin
        out_taken = 1'b0;
        if ($urandom_range(0, 19) == 0) out_burst = ~out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 9);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitors and watchdog
  always @(posedge clk_i) begin
    bit moved;
    moved = 1'b0;
    if (reset_done && in_ch.valid && in_ch.ready) begin
      sample_word_t w;
      w.sample = in_ch.sample;
      w.first  = in_ch.first_of_signal;
      predict_sample(w);
      in_taken = 1'b1;
      moved = 1'b1;
    end
    if (reset_done && out_ch.valid && out_ch.ready) begin
      out_taken = 1'b1;
      moved = 1'b1;
      if (expected_bins.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected bin: index %0d value %0d last %0b",
                   out_ch.bin_index, out_ch.bin_value, out_ch.last_bin);
      end else begin
        bin_word_t e;
        e = expected_bins.pop_front();
        bins_checked++;
        if (e.idx !== out_ch.bin_index || e.val !== out_ch.bin_value ||
            e.last !== out_ch.last_bin) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"bin mismatch: expected idx %0d val %0d last %0b,",
                      " got idx %0d val %0d last %0b"},
                     e.idx, e.val, e.last, out_ch.bin_index, out_ch.bin_value,
                     out_ch.last_bin);
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d bins still expected", expected_bins.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int mode;
    int nfr;
    int unsigned hop;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = psf_pkg::REG_HOP;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.first_of_signal = 1'b0;
    out_ch.ready = 1'b0;
    mismatches = 0;
    samples_sent = 0;
    frames_seen = 0;
    bins_checked = 0;
    idle_cycles = 0;
    drv_busy = 0;
    in_taken = 0;
    out_taken = 0;
    in_gap = 0;
    out_stall = 0;
    in_burst = 0;
    out_burst = 0;
    fill_cnt = 0;
    hop_cnt = 0;
    wr_ptr = 0;
    hop_len = 7'd32;
    scale_mult = 32'd65536;
    scale_shift = 6'd16;
    log_on = 1'b0;
    log_eps = 16'd1;
    for (int n = 0; n < N; n++) begin
      frame_buf[n] = '0;
      hann[n] = (32768 - cos_of_turn(((n * 65536 + (N - 1) / 2) / (N - 1)) & 16'hFFFF)
                 + 1) / 2;
      cos_tab[n] = cos_of_turn(n * (65536 / N));
      sin_tab[n] = cos_of_turn((n * (65536 / N) - 16384) & 16'hFFFF);
    end
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    reset_done = 1'b1;

    // directed: full-scale square wave at reset defaults, then a partial signal
    // that the next restart drops
    for (int i = 0; i < N + 32; i++) queue_word((i % 2) ? 16'sh8000 : 16'sh7FFF, i == 0);
    for (int i = 0; i < 5; i++) queue_word(16'sh7FFF, i == 0);
    wait_quiet();

    // directed: log of zero, extremes of shift and offset, zero hop, long hop
    write_reg(psf_pkg::REG_MULT, 32'd0);
    write_reg(psf_pkg::REG_LOG, 32'd1);
    write_reg(psf_pkg::REG_OFFSET, 32'd0);
    write_reg(psf_pkg::REG_HOP, 32'd0);
    push_signal(2, 2);
    wait_quiet();
    write_reg(psf_pkg::REG_MULT, 32'hFFFF_FFFF);
    write_reg(psf_pkg::REG_SHIFT, 32'd0);
    write_reg(psf_pkg::REG_OFFSET, 32'd65535);
    write_reg(psf_pkg::REG_HOP, 32'd16);
    push_signal(1, 2);
    wait_quiet();
    write_reg(psf_pkg::REG_SHIFT, 32'd63);
    write_reg(psf_pkg::REG_LOG, 32'd0);
    write_reg(psf_pkg::REG_HOP, 32'd70);
    push_signal(2, 0);
    wait_quiet();

    // random phases
    while (samples_sent < 450) begin
      case ($urandom_range(0, 7))
        0: write_reg(psf_pkg::REG_HOP, $urandom_range(0, 2));
        1: write_reg(psf_pkg::REG_HOP, $urandom_range(65, 127));
        default: write_reg(psf_pkg::REG_HOP, $urandom_range(8, 64));
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(psf_pkg::REG_MULT, 32'hFFFF_FFFF);
        1: write_reg(psf_pkg::REG_MULT, $urandom_range(0, 1) ? 32'd0 : 32'd65536);
        default: write_reg(psf_pkg::REG_MULT, $urandom);
      endcase
      write_reg(psf_pkg::REG_SHIFT, $urandom_range(0, 3) == 0 ? 63 : $urandom_range(0, 48));
      write_reg(psf_pkg::REG_LOG, $urandom_range(0, 1));
      write_reg(psf_pkg::REG_OFFSET,
                $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 65535));
      hop = (hop_len == 0) ? 1 : hop_len;
      mode = $urandom_range(0, 2);
      // broken signal first now and then: restart, partial fill, dropped
      if ($urandom_range(0, 3) == 0)
        for (int i = $urandom_range(1, N - 1); i > 0; i--)
          queue_word(draw_sample(mode), i == 1 || $urandom_range(0, 9) == 0);
      nfr = (hop <= 4) ? $urandom_range(2, 8) : (hop > N) ? 1 : $urandom_range(1, 5);
      push_signal(nfr, mode);
      wait_quiet();
    end

    wait_quiet();
    $display("Sent %0d samples over many register settings; %0d frames, %0d bins checked.",
             samples_sent, frames_seen, bins_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d mismatching bins", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
sv/psf_pkg.sv
sv/psf_in_if.sv
sv/psf_out_if.sv
sv/psf_mul.sv
sv/power_spectrogram_frames_unit.sv
dv/tb_top.sv
